// File: rtl/pes_reassembly_controller_core_macros.svh
// assertion macros for the pes reassembly controller
// no dependencies; included by files that carry concurrent checks
`ifndef PES_REASSEMBLY_CONTROLLER_CORE_MACROS_SVH
`define PES_REASSEMBLY_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PESRC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("pesrc check failed");
`define PESRC_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("pesrc check failed");
`else
`define PESRC_ASSERT(lbl, clk_s, rstn_s, prop)
`define PESRC_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

// File: rtl/pesrc_pkg.sv
// types, constants and verdict codes for the pes reassembly controller
// no dependencies
`timescale 1ns / 1ps
package pesrc_pkg;

  localparam int PID_COUNT  = 8192;
  localparam int PID_BITS   = $clog2(PID_COUNT);
  localparam int PID_W      = 13;
  localparam int SIZE_BITS  = 20;
  localparam int OUT_SIZE_W = 20;
  localparam int CC_W       = 4;
  localparam int SCR_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 16;

  localparam logic [SCR_W-1:0]  SCR_NONE       = 2'd0;
  localparam logic [BYTE_W-1:0] START_CODE_LOW = 8'h00;
  localparam logic [BYTE_W-1:0] START_CODE_END = 8'h01;
  localparam int                HDR_LEN_OFFSET = 4;
  localparam int                MIN_PES        = 6;
  localparam int                MIN_START      = 3;

  typedef enum logic [3:0] {
    V_BAD_SYNC   = 4'd0,
    V_NO_CONTEXT = 4'd1,
    V_SCRAMBLED  = 4'd2,
    V_STARTED    = 4'd3,
    V_NOT_PES    = 4'd4,
    V_UNSYNCED   = 4'd5,
    V_DUPLICATE  = 4'd6,
    V_SYNC_LOST  = 4'd7,
    V_APPENDED   = 4'd8
  } verdict_t;

  typedef struct packed {
    logic                 valid;
    logic                 sync;
    logic [CC_W-1:0]      cc;
    logic [SIZE_BITS-1:0] size;
    logic [BYTE_W-1:0]    len_hi;
    logic [BYTE_W-1:0]    len_lo;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

  typedef struct packed {
    logic              sync_ok;
    logic [PID_W-1:0]  pid;
    logic              unit_start;
    logic [CC_W-1:0]   cc;
    logic [SCR_W-1:0]  scrambling;
    logic [BYTE_W-1:0] payload_size;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] b4;
    logic [BYTE_W-1:0] b5;
  } item_t;

endpackage

// File: rtl/pesrc_in_if.sv
// packet beat channel into the pes reassembly controller
// depends on pesrc_pkg
`timescale 1ns / 1ps
interface pesrc_in_if
  import pesrc_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              header_sync_ok;
  logic [PID_W-1:0]  pid;
  logic              unit_start;
  logic [CC_W-1:0]   continuity_count;
  logic [SCR_W-1:0]  scrambling;
  logic [BYTE_W-1:0] payload_size;
  logic [BYTE_W-1:0] byte_zero;
  logic [BYTE_W-1:0] byte_one;
  logic [BYTE_W-1:0] byte_two;
  logic [BYTE_W-1:0] byte_three;
  logic [BYTE_W-1:0] byte_four;
  logic [BYTE_W-1:0] byte_five;

  modport source (
    output valid, header_sync_ok, pid, unit_start, continuity_count, scrambling,
           payload_size, byte_zero, byte_one, byte_two, byte_three, byte_four,
           byte_five,
    input  ready
  );
  modport sink (
    input  valid, header_sync_ok, pid, unit_start, continuity_count, scrambling,
           payload_size, byte_zero, byte_one, byte_two, byte_three, byte_four,
           byte_five,
    output ready
  );
endinterface

// File: rtl/pesrc_out_if.sv
// verdict beat channel out of the pes reassembly controller
// depends on pesrc_pkg
`timescale 1ns / 1ps
interface pesrc_out_if
  import pesrc_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [3:0]            verdict;
  logic                  flushed;
  logic [OUT_SIZE_W-1:0] flushed_size;
  logic                  completed;
  logic [OUT_SIZE_W-1:0] completed_size;
  logic [PID_W-1:0]      pid_out;
  logic                  overflow;

  modport source (
    output valid, verdict, flushed, flushed_size, completed, completed_size,
           pid_out, overflow,
    input  ready
  );
  modport sink (
    input  valid, verdict, flushed, flushed_size, completed, completed_size,
           pid_out, overflow,
    output ready
  );
endinterface

// File: rtl/pes_reassembly_controller_core.sv
// pes reassembly controller: per-pid context memory with read-modify-write
// depends on pesrc_pkg, pesrc_in_if, pesrc_out_if and the assertion macros
`timescale 1ns / 1ps
`include "pes_reassembly_controller_core_macros.svh"
// For each packet beat the context entry of its pid is read from the
// context memory in the accept cycle; in S_CALC the verdict is formed, the
// entry written back and the result loaded into the output register, once
// that register is free. A new packet is taken while a result still waits,
// but the block stays in S_CALC until the output register is free.
// After reset the context memory is swept clear, one entry per cycle, and
// no packet is accepted until all PID_COUNT (8192) entries are cleared.
module pes_reassembly_controller_core
  import pesrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pesrc_in_if.sink   in_bus,
  pesrc_out_if.source out_bus
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CALC  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PID_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t               item_r;
  logic [CTX_W-1:0]    ctx_mem [PID_COUNT];
  logic [CTX_W-1:0]    rd_data_r;

  logic                  out_valid_r;
  verdict_t              verdict_r;
  logic                  flushed_r;
  logic [OUT_SIZE_W-1:0] flushed_size_r;
  logic                  completed_r;
  logic [OUT_SIZE_W-1:0] completed_size_r;
  logic [PID_W-1:0]      pid_out_r;
  logic                  overflow_r;

  logic                  in_fire, out_free, calc_done;
  logic                  mem_we;
  logic [PID_BITS-1:0]   mem_waddr;
  logic [CTX_W-1:0]      mem_wdata;

  ctx_t                  ctx, ctx_nxt;
  logic                  wr_ctx;
  verdict_t              verdict_nxt;
  logic                  flushed_nxt, completed_nxt, overflow_nxt;
  logic [OUT_SIZE_W-1:0] flushed_size_nxt, completed_size_nxt;
  logic [BYTE_W-1:0]     pb [6];
  logic                  pid_ok, start_ok;
  logic [SIZE_BITS:0]    sum_w;
  logic [SIZE_BITS-1:0]  size_sat;
  logic [2:0]            hi_idx, lo_idx;
  logic [LEN_W-1:0]      len_v;
  ctx_t                  app_ctx;
  logic                  chk_append_flags, chk_start_verdict;

  assign in_fire   = in_bus.valid && in_bus.ready;
  assign out_free  = !out_valid_r || out_bus.ready;
  assign calc_done = (state_r == S_CALC) && out_free;
  assign in_bus.ready = (state_r == S_IDLE);

  // control
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == PID_BITS'(PID_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= '{sync_ok:      in_bus.header_sync_ok,
                  pid:          in_bus.pid,
                  unit_start:   in_bus.unit_start,
                  cc:           in_bus.continuity_count,
                  scrambling:   in_bus.scrambling,
                  payload_size: in_bus.payload_size,
                  b0:           in_bus.byte_zero,
                  b1:           in_bus.byte_one,
                  b2:           in_bus.byte_two,
                  b3:           in_bus.byte_three,
                  b4:           in_bus.byte_four,
                  b5:           in_bus.byte_five};
    end
  end

  // context memory
  assign mem_we    = (state_r == S_CLEAR) || (calc_done && wr_ctx);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : item_r.pid[PID_BITS-1:0];
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : CTX_W'(ctx_nxt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ctx_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_r <= ctx_mem[in_bus.pid[PID_BITS-1:0]];
    end
  end

  // verdict and context update
  assign ctx    = ctx_t'(rd_data_r);
  assign pid_ok = ({1'b0, item_r.pid} < (PID_W + 1)'(PID_COUNT));
  assign pb[0]  = item_r.b0;
  assign pb[1]  = item_r.b1;
  assign pb[2]  = item_r.b2;
  assign pb[3]  = item_r.b3;
  assign pb[4]  = item_r.b4;
  assign pb[5]  = item_r.b5;

  assign start_ok = (item_r.payload_size >= BYTE_W'(MIN_START)) &&
                    (item_r.b0 == START_CODE_LOW) && (item_r.b1 == START_CODE_LOW) &&
                    (item_r.b2 == START_CODE_END);

  // append path
  assign sum_w    = {1'b0, ctx.size} + (SIZE_BITS + 1)'(item_r.payload_size);
  assign size_sat = sum_w[SIZE_BITS] ? '1 : sum_w[SIZE_BITS-1:0];
  assign hi_idx   = 3'(HDR_LEN_OFFSET) - ctx.size[2:0];
  assign lo_idx   = 3'(HDR_LEN_OFFSET + 1) - ctx.size[2:0];

  always_comb begin
    app_ctx      = ctx;
    app_ctx.cc   = item_r.cc;
    app_ctx.size = size_sat;
    if ((ctx.size <= SIZE_BITS'(HDR_LEN_OFFSET)) &&
        (sum_w > (SIZE_BITS + 1)'(HDR_LEN_OFFSET))) begin
      app_ctx.len_hi = pb[hi_idx];
    end
    if ((ctx.size <= SIZE_BITS'(HDR_LEN_OFFSET + 1)) &&
        (sum_w > (SIZE_BITS + 1)'(HDR_LEN_OFFSET + 1))) begin
      app_ctx.len_lo = pb[lo_idx];
    end
  end

  assign len_v = {app_ctx.len_hi, app_ctx.len_lo};

  always_comb begin
    ctx_nxt            = ctx;
    wr_ctx             = 1'b0;
    verdict_nxt        = V_BAD_SYNC;
    flushed_nxt        = 1'b0;
    flushed_size_nxt   = '0;
    completed_nxt      = 1'b0;
    completed_size_nxt = '0;
    overflow_nxt       = 1'b0;
    if (!item_r.sync_ok) begin
      verdict_nxt = V_BAD_SYNC;
    end else if (!pid_ok) begin
      verdict_nxt = V_NO_CONTEXT;
    end else if (!ctx.valid && !item_r.unit_start) begin
      verdict_nxt = V_NO_CONTEXT;
    end else if (item_r.unit_start) begin
      if (ctx.valid && ctx.sync && (ctx.size >= SIZE_BITS'(MIN_PES))) begin
        flushed_nxt      = 1'b1;
        flushed_size_nxt = OUT_SIZE_W'(ctx.size);
      end
      wr_ctx  = 1'b1;
      ctx_nxt = '0;
      if (item_r.scrambling != SCR_NONE) begin
        verdict_nxt = V_SCRAMBLED;
      end else if (start_ok) begin
        verdict_nxt    = V_STARTED;
        ctx_nxt.valid  = 1'b1;
        ctx_nxt.sync   = 1'b1;
        ctx_nxt.cc     = item_r.cc;
        ctx_nxt.size   = SIZE_BITS'(item_r.payload_size);
        if (item_r.payload_size > BYTE_W'(HDR_LEN_OFFSET)) begin
          ctx_nxt.len_hi = item_r.b4;
        end
        if (item_r.payload_size > BYTE_W'(HDR_LEN_OFFSET + 1)) begin
          ctx_nxt.len_lo = item_r.b5;
        end
      end else begin
        verdict_nxt = V_NOT_PES;
      end
    end else if (item_r.scrambling != SCR_NONE) begin
      wr_ctx      = 1'b1;
      ctx_nxt     = '0;
      verdict_nxt = V_SCRAMBLED;
    end else if (!ctx.sync) begin
      verdict_nxt = V_UNSYNCED;
    end else if (item_r.cc == ctx.cc) begin
      verdict_nxt = V_DUPLICATE;
    end else if (item_r.cc != (ctx.cc + 1'b1)) begin
      wr_ctx       = 1'b1;
      ctx_nxt.sync = 1'b0;
      ctx_nxt.size = '0;
      verdict_nxt  = V_SYNC_LOST;
    end else begin
      wr_ctx       = 1'b1;
      ctx_nxt      = app_ctx;
      overflow_nxt = sum_w[SIZE_BITS];
      verdict_nxt  = V_APPENDED;
      if ((size_sat >= SIZE_BITS'(MIN_PES)) && (len_v != '0) &&
          ((SIZE_BITS + 1)'(size_sat) >=
           ((SIZE_BITS + 1)'(len_v) + (SIZE_BITS + 1)'(HDR_LEN_OFFSET)))) begin
        completed_nxt      = 1'b1;
        completed_size_nxt = OUT_SIZE_W'(size_sat);
        ctx_nxt.size       = '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (calc_done) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_done) begin
      verdict_r        <= verdict_nxt;
      flushed_r        <= flushed_nxt;
      flushed_size_r   <= flushed_size_nxt;
      completed_r      <= completed_nxt;
      completed_size_r <= completed_size_nxt;
      pid_out_r        <= item_r.pid;
      overflow_r       <= overflow_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.verdict        = verdict_r;
  assign out_bus.flushed        = flushed_r;
  assign out_bus.flushed_size   = flushed_size_r;
  assign out_bus.completed      = completed_r;
  assign out_bus.completed_size = completed_size_r;
  assign out_bus.pid_out        = pid_out_r;
  assign out_bus.overflow       = overflow_r;

  // checks
  assign chk_append_flags  = out_valid_r && (completed_r || overflow_r);
  assign chk_start_verdict = (verdict_r == V_SCRAMBLED) || (verdict_r == V_STARTED) ||
                             (verdict_r == V_NOT_PES);

  `PESRC_ASSERT(a_accept_to_calc, clk, rst_n, in_fire |=> (state_r == S_CALC))
  `PESRC_ASSERT(a_no_accept_in_clear, clk, rst_n, (state_r == S_CLEAR) |-> !in_bus.ready)
  `PESRC_ASSERT(a_complete_on_append, clk, rst_n, chk_append_flags |-> (verdict_r == V_APPENDED))
  `PESRC_ASSERT(a_flush_on_start, clk, rst_n, (out_valid_r && flushed_r) |-> chk_start_verdict)

endmodule

// File: bench/tb_pes_reassembly_controller_core.sv
// self-checking bench for the pes reassembly controller: directed packet rows and
// random per-pid packet streams, scored against a context-table predictor
// depends on pesrc_pkg, pesrc_in_if, pesrc_out_if and pes_reassembly_controller_core
`timescale 1ns / 1ps
module tb_pes_reassembly_controller_core;
  import pesrc_pkg::*;

  localparam int                   POOL_N     = 8;
  localparam int unsigned          RAND_PKTS  = 590;
  localparam logic [SIZE_BITS:0]   SIZE_LIMIT = (SIZE_BITS + 1)'((1 << SIZE_BITS) - 1);

  typedef struct packed {
    logic [3:0]            verdict;
    logic                  flushed;
    logic [OUT_SIZE_W-1:0] flushed_size;
    logic                  completed;
    logic [OUT_SIZE_W-1:0] completed_size;
    logic [PID_W-1:0]      pid;
    logic                  overflow;
  } verdict_beat_t;

  typedef struct {
    item_t         pkt;
    logic          known;
    verdict_beat_t want;
  } packet_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pesrc_in_if  in_bus ();
  pesrc_out_if out_bus ();

  pes_reassembly_controller_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  ctx_t             pid_contexts [PID_COUNT];
  verdict_beat_t    pending_verdicts [$];
  packet_row_t      directed_rows [$];
  logic [PID_W-1:0] pid_pool [POOL_N];
  logic [CC_W-1:0]  pool_cc [POOL_N];

  logic          row_known;
  verdict_beat_t row_want;
  int unsigned   src_gap_pct;
  int unsigned   sink_gap_pct;
  int unsigned   failures;
  int unsigned   packets_sent;
  int unsigned   beats_checked;
  int unsigned   flushes_seen;
  int unsigned   completions_seen;
  int unsigned   overflows_seen;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic item_t pkt(logic s, logic [PID_W-1:0] pid, logic us, logic [CC_W-1:0] cc,
                                logic [SCR_W-1:0] scr, logic [BYTE_W-1:0] n, logic [47:0] pay);
    item_t p;
    p.sync_ok      = s;
    p.pid          = pid;
    p.unit_start   = us;
    p.cc           = cc;
    p.scrambling   = scr;
    p.payload_size = n;
    {p.b0, p.b1, p.b2, p.b3, p.b4, p.b5} = pay;
    return p;
  endfunction

  function automatic verdict_beat_t beat(verdict_t v, logic fl, logic [OUT_SIZE_W-1:0] fsz,
                                         logic cp, logic [OUT_SIZE_W-1:0] csz,
                                         logic [PID_W-1:0] pid, logic ov);
    verdict_beat_t r;
    r.verdict        = v;
    r.flushed        = fl;
    r.flushed_size   = fsz;
    r.completed      = cp;
    r.completed_size = csz;
    r.pid            = pid;
    r.overflow       = ov;
    return r;
  endfunction

  // pes length field sits at gathered offsets 4 and 5
  function automatic ctx_t take_length(ctx_t c, int unsigned old, int unsigned n,
                                       logic [47:0] pay);
    if (old <= 4 && old + n > 4) c.len_hi = pay[47 - 8 * (4 - old) -: 8];
    if (old <= 5 && old + n > 5) c.len_lo = pay[47 - 8 * (5 - old) -: 8];
    return c;
  endfunction

  function automatic verdict_beat_t predict_verdict(item_t p);
    verdict_beat_t    r;
    ctx_t             c;
    logic [47:0]      pay;
    logic [SIZE_BITS:0] total;
    logic [LEN_W-1:0] len_field;
    logic [CC_W-1:0]  next_cc;
    int unsigned      old_size;
    r     = '0;
    r.pid = p.pid;
    pay   = {p.b0, p.b1, p.b2, p.b3, p.b4, p.b5};
    if (!p.sync_ok) begin
      r.verdict = V_BAD_SYNC;
    end else begin
      c = pid_contexts[p.pid];
      next_cc = c.cc + 1'b1;
      if (p.unit_start) begin
        if (c.valid && c.sync && c.size >= MIN_PES) begin
          r.flushed      = 1'b1;
          r.flushed_size = c.size;
        end
        c = '0;
        if (p.scrambling != SCR_NONE) begin
          r.verdict = V_SCRAMBLED;
        end else if (p.payload_size >= MIN_START && p.b0 == START_CODE_LOW &&
                     p.b1 == START_CODE_LOW && p.b2 == START_CODE_END) begin
          c.valid = 1'b1;
          c.sync  = 1'b1;
          c.cc    = p.cc;
          c.size  = SIZE_BITS'(p.payload_size);
          c       = take_length(c, 0, p.payload_size, pay);
          r.verdict = V_STARTED;
        end else begin
          r.verdict = V_NOT_PES;
        end
      end else if (!c.valid) begin
        r.verdict = V_NO_CONTEXT;
      end else if (p.scrambling != SCR_NONE) begin
        c = '0;
        r.verdict = V_SCRAMBLED;
      end else if (!c.sync) begin
        r.verdict = V_UNSYNCED;
      end else if (p.cc == c.cc) begin
        r.verdict = V_DUPLICATE;
      end else if (p.cc != next_cc) begin
        c.sync = 1'b0;
        c.size = '0;
        r.verdict = V_SYNC_LOST;
      end else begin
        old_size = c.size;
        total = {1'b0, c.size} + (SIZE_BITS + 1)'(p.payload_size);
        c.cc = p.cc;
        c = take_length(c, old_size, p.payload_size, pay);
        if (total > SIZE_LIMIT) begin
          total = SIZE_LIMIT;
          r.overflow = 1'b1;
        end
        c.size = total[SIZE_BITS-1:0];
        len_field = {c.len_hi, c.len_lo};
        if (c.size >= MIN_PES && len_field != 0 && c.size >= HDR_LEN_OFFSET + len_field) begin
          r.completed      = 1'b1;
          r.completed_size = c.size;
          c.size = '0;
        end
        r.verdict = V_APPENDED;
      end
      pid_contexts[p.pid] = c;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    item_t         seen;
    verdict_beat_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("verdict beat for pid %0d with none expected", out_bus.pid_out);
          failures++;
        end else begin
          want = pending_verdicts.pop_front();
          compare_field("verdict", 32'(want.verdict), 32'(out_bus.verdict));
          compare_field("flushed", 32'(want.flushed), 32'(out_bus.flushed));
          compare_field("flushed_size", 32'(want.flushed_size), 32'(out_bus.flushed_size));
          compare_field("completed", 32'(want.completed), 32'(out_bus.completed));
          compare_field("completed_size", 32'(want.completed_size),
                        32'(out_bus.completed_size));
          compare_field("pid_out", 32'(want.pid), 32'(out_bus.pid_out));
          compare_field("overflow", 32'(want.overflow), 32'(out_bus.overflow));
          beats_checked++;
          if (out_bus.flushed) flushes_seen++;
          if (out_bus.completed) completions_seen++;
          if (out_bus.overflow) overflows_seen++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        seen = pkt(in_bus.header_sync_ok, in_bus.pid, in_bus.unit_start,
                   in_bus.continuity_count, in_bus.scrambling, in_bus.payload_size,
                   {in_bus.byte_zero, in_bus.byte_one, in_bus.byte_two,
                    in_bus.byte_three, in_bus.byte_four, in_bus.byte_five});
        want = predict_verdict(seen);
        if (row_known) want = row_want;
        pending_verdicts.push_back(want);
      end
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= sink_gap_pct);
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_packet(item_t p, logic known, verdict_beat_t want);
    row_known = known;
    row_want  = want;
    while ($urandom_range(99) < src_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid            <= 1'b1;
    in_bus.header_sync_ok   <= p.sync_ok;
    in_bus.pid              <= p.pid;
    in_bus.unit_start       <= p.unit_start;
    in_bus.continuity_count <= p.cc;
    in_bus.scrambling       <= p.scrambling;
    in_bus.payload_size     <= p.payload_size;
    in_bus.byte_zero        <= p.b0;
    in_bus.byte_one         <= p.b1;
    in_bus.byte_two         <= p.b2;
    in_bus.byte_three       <= p.b3;
    in_bus.byte_four        <= p.b4;
    in_bus.byte_five        <= p.b5;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    packets_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // mostly well-formed streams on a small pid pool, with duplicates, gaps,
  // scrambled and non-pes starts and some noise mixed in
  task automatic send_random_packets(int unsigned wanted);
    int unsigned      taken;
    int unsigned      k;
    int unsigned      slot;
    int unsigned      lsel;
    logic [95:0]      rnd;
    logic [LEN_W-1:0] len_field;
    item_t            p;
    taken = 0;
    while (taken < wanted) begin
      k    = $urandom_range(99);
      slot = $urandom_range(POOL_N - 1);
      rnd  = {$urandom, $urandom, $urandom};
      p = pkt(1'b1, pid_pool[slot], 1'b0, pool_cc[slot] + 1'b1, SCR_NONE,
              ($urandom_range(9) == 0) ? rnd[76:69] : 8'd184, rnd[47:0]);
      if (k < 12) begin
        lsel = $urandom_range(9);
        len_field = (lsel == 0) ? 16'd0 :
                    (lsel == 1) ? 16'hFFFF : 16'($urandom_range(900, 1));
        p.unit_start   = 1'b1;
        p.cc           = rnd[64:61];
        p.payload_size = 8'($urandom_range(184, 3));
        p.b0 = START_CODE_LOW;
        p.b1 = START_CODE_LOW;
        p.b2 = START_CODE_END;
        {p.b4, p.b5} = len_field;
      end else if (k < 75) begin
        // next count, payload appended
      end else if (k < 80) begin
        p.cc = pool_cc[slot];
      end else if (k < 84) begin
        p.cc = pool_cc[slot] + 4'($urandom_range(15, 2));
      end else if (k < 88) begin
        p.scrambling = 2'($urandom_range(3, 1));
        p.unit_start = rnd[68];
      end else if (k < 91) begin
        p.sync_ok = 1'b0;
        p.unit_start = rnd[68];
        p.scrambling = rnd[66:65];
      end else if (k < 95) begin
        p.unit_start = 1'b1;
        p.cc = rnd[64:61];
        if (rnd[68]) begin
          p.b0 = START_CODE_LOW;
          p.b1 = START_CODE_LOW;
          p.b2 = START_CODE_END;
          p.payload_size = 8'($urandom_range(2));
        end
      end else begin
        p = pkt(rnd[67], rnd[60:48], rnd[68], rnd[64:61], rnd[66:65], rnd[76:69],
                rnd[47:0]);
      end
      send_packet(p, 1'b0, '0);
      if (p.pid == pid_pool[slot] && p.sync_ok) pool_cc[slot] = p.cc;
      if (p.sync_ok) taken++;
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    in_bus.valid            = 1'b0;
    in_bus.header_sync_ok   = 1'b0;
    in_bus.pid              = '0;
    in_bus.unit_start       = 1'b0;
    in_bus.continuity_count = '0;
    in_bus.scrambling       = '0;
    in_bus.payload_size     = '0;
    in_bus.byte_zero        = '0;
    in_bus.byte_one         = '0;
    in_bus.byte_two         = '0;
    in_bus.byte_three       = '0;
    in_bus.byte_four        = '0;
    in_bus.byte_five        = '0;
    out_bus.ready           = 1'b0;
    rst_n                   = 1'b0;
    row_known               = 1'b0;
    row_want                = '0;
    src_gap_pct             = 13;
    sink_gap_pct            = 49;
    failures                = 0;
    packets_sent            = 0;
    beats_checked           = 0;
    flushes_seen            = 0;
    completions_seen        = 0;
    overflows_seen          = 0;
    for (i = 0; i < PID_COUNT; i++) pid_contexts[i] = '0;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (i = 2; i < POOL_N; i++) pid_pool[i] = 13'($urandom_range(8191));
    for (i = 0; i < POOL_N; i++) pool_cc[i] = '0;

    directed_rows.push_back('{pkt(1'b0, 13'd8191, 1'b1, 4'd15, 2'd3, 8'd255, 48'hFFFFFFFFFFFF),
      1'b1, beat(V_BAD_SYNC, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd0, 1'b0, 4'd0, SCR_NONE, 8'd0, 48'h0),
      1'b1, beat(V_NO_CONTEXT, 1'b0, 20'd0, 1'b0, 20'd0, 13'd0, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd5, 1'b1, 4'd0, SCR_NONE, 8'd184, 48'h4711223344AA),
      1'b1, beat(V_NOT_PES, 1'b0, 20'd0, 1'b0, 20'd0, 13'd5, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd6, 1'b1, 4'd0, SCR_NONE, 8'd2, 48'h000001E00000),
      1'b1, beat(V_NOT_PES, 1'b0, 20'd0, 1'b0, 20'd0, 13'd6, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd7, 1'b1, 4'd0, 2'd2, 8'd10, 48'h000001E00010),
      1'b1, beat(V_SCRAMBLED, 1'b0, 20'd0, 1'b0, 20'd0, 13'd7, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b1, 4'd15, SCR_NONE, 8'd184, 48'h000001E0000C),
      1'b1, beat(V_STARTED, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd15, SCR_NONE, 8'd184, 48'h555555555555),
      1'b1, beat(V_DUPLICATE, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    // count wraps 15 to 0, length 12 already passed
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd0, SCR_NONE, 8'd10, 48'hA5A5A5A5A5A5),
      1'b1, beat(V_APPENDED, 1'b0, 20'd0, 1'b1, 20'd194, 13'd8191, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd1, SCR_NONE, 8'd0, 48'h0),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd3, SCR_NONE, 8'd184, 48'h0),
      1'b1, beat(V_SYNC_LOST, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd4, SCR_NONE, 8'd184, 48'h0),
      1'b1, beat(V_UNSYNCED, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd5, 2'd1, 8'd184, 48'h0),
      1'b1, beat(V_SCRAMBLED, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd8191, 1'b0, 4'd6, SCR_NONE, 8'd184, 48'h0),
      1'b1, beat(V_NO_CONTEXT, 1'b0, 20'd0, 1'b0, 20'd0, 13'd8191, 1'b0)});
    // length bytes arriving in a later packet
    directed_rows.push_back('{pkt(1'b1, 13'd100, 1'b1, 4'd0, SCR_NONE, 8'd3, 48'h000001FFFFFF),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd100, 1'b0, 4'd1, SCR_NONE, 8'd1, 48'hAA0000000000),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd100, 1'b0, 4'd2, SCR_NONE, 8'd2, 48'h0002FFFFFFFF),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd100, 1'b0, 4'd3, SCR_NONE, 8'd255, 48'h123456789ABC),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd100, 1'b1, 4'd7, SCR_NONE, 8'd184, 48'h000001E00000),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd100, 1'b1, 4'd8, 2'd3, 8'd184, 48'h000001E00000),
      1'b1, beat(V_SCRAMBLED, 1'b1, 20'd184, 1'b0, 20'd0, 13'd100, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd200, 1'b1, 4'd0, SCR_NONE, 8'd6, 48'h000001BDFFFF),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd200, 1'b1, 4'd1, SCR_NONE, 8'd0, 48'h0),
      1'b1, beat(V_NOT_PES, 1'b1, 20'd6, 1'b0, 20'd0, 13'd200, 1'b0)});
    directed_rows.push_back('{pkt(1'b1, 13'd0, 1'b1, 4'd9, SCR_NONE, 8'd184, 48'h000001C00000),
      1'b0, '0});
    directed_rows.push_back('{pkt(1'b1, 13'd0, 1'b1, 4'd10, SCR_NONE, 8'd184, 48'h000001C00000),
      1'b1, beat(V_STARTED, 1'b1, 20'd184, 1'b0, 20'd0, 13'd0, 1'b0)});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[j]) send_packet(directed_rows[j].pkt, directed_rows[j].known,
                                           directed_rows[j].want);
    send_random_packets(RAND_PKTS);
    hold_until_drained();

    src_gap_pct  = 49;
    sink_gap_pct = 13;
    send_random_packets(RAND_PKTS);
    hold_until_drained();

    src_gap_pct  = 0;
    sink_gap_pct = 0;
    send_random_packets(RAND_PKTS);
    hold_until_drained();
    repeat (8) @(posedge clk);

    $display("summary: %0d packets sent (%0d directed), %0d verdicts checked",
             packets_sent, directed_rows.size(), beats_checked);
    $display("summary: %0d flushes, %0d completions, %0d saturated appends, %0d mismatches",
             flushes_seen, completions_seen, overflows_seen, failures);
    if (failures == 0 && pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d verdicts still expected", pending_verdicts.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/pesrc_pkg.sv
rtl/pesrc_in_if.sv
rtl/pesrc_out_if.sv
rtl/pes_reassembly_controller_core.sv
bench/tb_pes_reassembly_controller_core.sv
